// File: src/particle_weight_normalize_resample_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the particle resampling core
// Shared forms for same-cycle and next-cycle checks, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_WEIGHT_NORMALIZE_RESAMPLE_CORE_ASSERT_SVH
`define PARTICLE_WEIGHT_NORMALIZE_RESAMPLE_CORE_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define PWNR_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pwnr: same-cycle check failed");

// pre holds -> post holds in the following cycle
`define PWNR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pwnr: next-cycle check failed");

`endif

// File: src/pwnr_pkg.sv
// ---------------------------------------------------------------------------
// pwnr_pkg
// Fixed widths, microcode field codes, control/status structs and the
// microprogram of the particle resampling core.
// ---------------------------------------------------------------------------
package pwnr_pkg;

  // Field and accumulator widths
  localparam int PROB_W  = 16;
  localparam int LIK_W   = 16;
  localparam int RND_W   = 16;
  localparam int CFG_W   = 7;
  localparam int OIDX_W  = 6;
  localparam int WGT_W   = 32;
  localparam int TOT_W   = 38;
  localparam int LHS_W   = 60;
  localparam int RHS_W   = 45;
  localparam int FRAC_W  = 16;
  localparam int CMP_W   = RHS_W + FRAC_W;

  // 0.00001 in Q8.24, rounded down
  localparam logic [TOT_W-1:0] ZERO_THRESH = 38'd167;

  // Step counter
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_MULW   = 4'd1;
  localparam step_t S_STORE  = 4'd2;
  localparam step_t S_SETUP  = 4'd3;
  localparam step_t S_PREP   = 4'd4;
  localparam step_t S_ACC    = 4'd5;
  localparam step_t S_TEST   = 4'd6;
  localparam step_t S_FETCH  = 4'd7;
  localparam step_t S_EMIT   = 4'd8;
  localparam step_t S_FINISH = 4'd9;

  // Hold codes: the step stays until its condition is met
  typedef logic [1:0] hold_t;
  localparam hold_t H_NONE = 2'd0;
  localparam hold_t H_IN   = 2'd1;
  localparam hold_t H_OUT  = 2'd2;

  // Jump conditions
  typedef logic [2:0] jcond_t;
  localparam jcond_t J_NONE    = 3'd0;
  localparam jcond_t J_ALWAYS  = 3'd1;
  localparam jcond_t J_NOTLAST = 3'd2;
  localparam jcond_t J_NOWALK  = 3'd3;
  localparam jcond_t J_MORE    = 3'd4;

  typedef struct packed {
    logic   in_rdy;
    logic   mul_w;
    logic   store;
    logic   setup;
    logic   mul_lhs;
    logic   mul_prod;
    logic   acc_rhs;
    logic   test;
    logic   emit;
    logic   finish;
    hold_t  hold_on;
    jcond_t jcond;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic in_beat;
    logic out_free;
    logic last;
    logic walk;
    logic more;
  } status_t;

  // Microprogram: one control word per step
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      S_IDLE: begin
        c.in_rdy  = 1'b1;
        c.hold_on = H_IN;
      end
      S_MULW: begin
        c.mul_w = 1'b1;
      end
      S_STORE: begin
        c.store  = 1'b1;
        c.jcond  = J_NOTLAST;
        c.target = S_IDLE;
      end
      S_SETUP: begin
        c.setup = 1'b1;
      end
      S_PREP: begin
        c.mul_lhs  = 1'b1;
        c.mul_prod = 1'b1;
      end
      S_ACC: begin
        c.acc_rhs = 1'b1;
      end
      S_TEST: begin
        c.test   = 1'b1;
        c.jcond  = J_NOWALK;
        c.target = S_EMIT;
      end
      S_FETCH: begin
        c.mul_prod = 1'b1;
        c.jcond    = J_ALWAYS;
        c.target   = S_ACC;
      end
      S_EMIT: begin
        c.emit    = 1'b1;
        c.hold_on = H_OUT;
        c.jcond   = J_MORE;
        c.target  = S_TEST;
      end
      S_FINISH: begin
        c.finish = 1'b1;
        c.jcond  = J_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.jcond  = J_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: src/pwnr_if.sv
// ---------------------------------------------------------------------------
// pwnr channel interfaces
// Valid/ready channels for particle input, resampled index output and the
// draw count register write.
// ---------------------------------------------------------------------------
interface pwnr_in_if;
  logic                          valid;
  logic                          ready;
  logic [pwnr_pkg::PROB_W-1:0]   prob_in;
  logic [pwnr_pkg::LIK_W-1:0]    lik_in;
  logic [pwnr_pkg::RND_W-1:0]    rand_offset;
  logic                          batch_end;

  modport source (output valid, prob_in, lik_in, rand_offset, batch_end, input ready);
  modport sink   (input valid, prob_in, lik_in, rand_offset, batch_end, output ready);
endinterface

interface pwnr_out_if;
  logic                          valid;
  logic                          ready;
  logic [pwnr_pkg::OIDX_W-1:0]   chosen_index;
  logic                          uniform_fallback;
  logic                          run_end;

  modport source (output valid, chosen_index, uniform_fallback, run_end, input ready);
  modport sink   (input valid, chosen_index, uniform_fallback, run_end, output ready);
endinterface

interface pwnr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pwnr_pkg::CFG_W-1:0]    output_count;

  modport source (output valid, output_count, input ready);
  modport sink   (input valid, output_count, output ready);
endinterface

// File: src/pwnr_seq.sv
// ---------------------------------------------------------------------------
// pwnr_seq
// Step counter and microcode table lookup; holds, advances or jumps on
// datapath status.
// ---------------------------------------------------------------------------
module pwnr_seq (
  input  logic               clk,
  input  logic               rst,
  input  pwnr_pkg::status_t  stat,
  output pwnr_pkg::ctrl_t    ctrl
);

  pwnr_pkg::step_t pc;
  pwnr_pkg::step_t pc_next;
  logic            go;
  logic            taken;

  assign ctrl = pwnr_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.hold_on)
      pwnr_pkg::H_NONE: go = 1'b1;
      pwnr_pkg::H_IN:   go = stat.in_beat;
      pwnr_pkg::H_OUT:  go = stat.out_free;
      default:          go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctrl.jcond)
      pwnr_pkg::J_NONE:    taken = 1'b0;
      pwnr_pkg::J_ALWAYS:  taken = 1'b1;
      pwnr_pkg::J_NOTLAST: taken = !stat.last;
      pwnr_pkg::J_NOWALK:  taken = !stat.walk;
      pwnr_pkg::J_MORE:    taken = stat.more;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + pwnr_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pwnr_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: src/pwnr_dp.sv
// ---------------------------------------------------------------------------
// pwnr_dp
// Datapath: weight store, running total, cross-multiplied systematic walk
// and the registered output slot, all driven by the control word.
// ---------------------------------------------------------------------------
module pwnr_dp #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  pwnr_pkg::ctrl_t    ctrl,
  output pwnr_pkg::status_t  stat,
  pwnr_in_if.sink            particle,
  pwnr_out_if.source         draw,
  pwnr_cfg_if.sink           cfg
);

  localparam int IDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int PROD_W = pwnr_pkg::WGT_W + CNT_W;
  localparam int MUL_W  = pwnr_pkg::RND_W + pwnr_pkg::TOT_W;

  logic [pwnr_pkg::CFG_W-1:0]  output_count;
  logic [pwnr_pkg::PROB_W-1:0] prob;
  logic [pwnr_pkg::LIK_W-1:0]  lik;
  logic [pwnr_pkg::RND_W-1:0]  rnd;
  logic                        last;
  logic [pwnr_pkg::WGT_W-1:0]  wgt;
  logic [CNT_W-1:0]            count;
  logic [pwnr_pkg::TOT_W-1:0]  total;
  logic [CNT_W-1:0]            m_total;
  logic                        uniform;
  logic [pwnr_pkg::TOT_W-1:0]  s_val;
  logic [pwnr_pkg::LHS_W-1:0]  lhs;
  logic [pwnr_pkg::RHS_W-1:0]  rhs;
  logic [PROD_W-1:0]           prod;
  logic [IDX_W-1:0]            idx;
  logic [CNT_W-1:0]            draw_cnt;
  logic [pwnr_pkg::WGT_W-1:0]  rdata;
  logic [pwnr_pkg::WGT_W-1:0]  wmem [MAX_PARTICLES];

  logic                        out_valid;
  logic [pwnr_pkg::OIDX_W-1:0] out_idx;
  logic                        out_uni;
  logic                        out_end;

  logic                        in_beat;
  logic                        out_free;
  logic                        has_room;
  logic                        mem_we;
  logic [IDX_W-1:0]            raddr;
  logic [pwnr_pkg::CFG_W-1:0]  m_req;
  logic [pwnr_pkg::CFG_W-1:0]  m_sat;
  logic                        uni_now;
  logic [MUL_W-1:0]            lhs_init;
  logic [pwnr_pkg::WGT_W-1:0]  w_sel;
  logic [PROD_W-1:0]           prod_now;
  logic                        walk;
  logic                        more;
  logic                        do_emit;

  assign particle.ready = ctrl.in_rdy;
  assign cfg.ready      = 1'b1;
  assign in_beat        = particle.valid && ctrl.in_rdy;
  assign out_free       = !out_valid || draw.ready;
  assign do_emit        = ctrl.emit && out_free;

  assign has_room = count < CNT_W'(MAX_PARTICLES);
  assign mem_we   = ctrl.store && has_room;
  assign raddr    = ctrl.setup ? '0 : idx + IDX_W'(1);

  assign m_req   = (output_count == '0) ? pwnr_pkg::CFG_W'(count) : output_count;
  assign m_sat   = (m_req > pwnr_pkg::CFG_W'(MAX_PARTICLES)) ?
                   pwnr_pkg::CFG_W'(MAX_PARTICLES) : m_req;
  assign uni_now = total <= pwnr_pkg::ZERO_THRESH;

  assign lhs_init = MUL_W'(rnd) * MUL_W'(s_val);
  assign w_sel    = uniform ? pwnr_pkg::WGT_W'(1) : rdata;
  assign prod_now = PROD_W'(w_sel) * PROD_W'(m_total);

  // Step the walk while U*S > C*M, compared at the Q0.16 scale
  assign walk = ((CNT_W'(idx) + CNT_W'(1)) < count) &&
                (pwnr_pkg::CMP_W'(lhs) > {rhs, {pwnr_pkg::FRAC_W{1'b0}}});
  assign more = (draw_cnt + CNT_W'(1)) != m_total;

  assign stat.in_beat  = in_beat;
  assign stat.out_free = out_free;
  assign stat.last     = last;
  assign stat.walk     = walk;
  assign stat.more     = more;

  assign draw.valid            = out_valid;
  assign draw.chosen_index     = out_idx;
  assign draw.uniform_fallback = out_uni;
  assign draw.run_end          = out_end;

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[count[IDX_W-1:0]] <= wgt;
    end
    rdata <= wmem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      output_count <= '0;
      count        <= '0;
      total        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        output_count <= cfg.output_count;
      end
      if (mem_we) begin
        count <= count + CNT_W'(1);
        total <= total + pwnr_pkg::TOT_W'(wgt);
      end else if (ctrl.finish) begin
        count <= '0;
        total <= '0;
      end
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (draw.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      prob <= particle.prob_in;
      lik  <= particle.lik_in;
      rnd  <= particle.rand_offset;
      last <= particle.batch_end;
    end
    if (ctrl.mul_w) begin
      wgt <= pwnr_pkg::WGT_W'(prob) * pwnr_pkg::WGT_W'(lik);
    end
    if (ctrl.setup) begin
      m_total  <= CNT_W'(m_sat);
      uniform  <= uni_now;
      s_val    <= uni_now ? pwnr_pkg::TOT_W'(count) : total;
      idx      <= '0;
      draw_cnt <= '0;
      rhs      <= '0;
    end
    if (ctrl.mul_lhs) begin
      lhs <= pwnr_pkg::LHS_W'(lhs_init);
    end
    if (ctrl.mul_prod) begin
      prod <= prod_now;
    end
    if (ctrl.acc_rhs) begin
      rhs <= rhs + pwnr_pkg::RHS_W'(prod);
    end
    if (ctrl.test && walk) begin
      idx <= idx + IDX_W'(1);
    end
    if (do_emit) begin
      out_idx  <= pwnr_pkg::OIDX_W'(idx);
      out_uni  <= uniform;
      out_end  <= !more;
      draw_cnt <= draw_cnt + CNT_W'(1);
      lhs      <= lhs + pwnr_pkg::LHS_W'({s_val, {pwnr_pkg::FRAC_W{1'b0}}});
    end
  end

endmodule

// File: src/particle_weight_normalize_resample_core.sv
// ---------------------------------------------------------------------------
// particle_weight_normalize_resample_core
// Particle weight loader with low-variance systematic resampling, run by a
// small microprogram over a shared datapath.
// ---------------------------------------------------------------------------
// Each beat on the particle channel loads one particle: its weight is
// prob_in (Q0.16) times lik_in (Q8.8), kept exactly as Q8.24, and a 38-bit
// running total is updated. Up to MAX_PARTICLES particles are kept; beats
// past that are not stored, but a batch_end beat still triggers the draw.
// On the batch_end beat the core draws M indices with one start offset
// (rand_offset of that beat), where M is output_count, or the loaded count
// when output_count is zero, capped at MAX_PARTICLES. If the total is at or
// below 0.00001 every particle counts as weight one and uniform_fallback is
// set on every index. The test U > C/S is done cross-multiplied, so there is
// no divider, and the walk never passes the last loaded particle. run_end
// marks the last index of a batch, after which the batch is cleared.
// Steps: a load is accept, multiply, store. A batch_end beat adds the load
// steps, then setup (setup, prepare, accumulate), a walk step (compare,
// fetch, accumulate) each time the walk moves on, compare and emit per
// drawn index and a final clear step. Input and output stalls hold their
// step. The sequencer issues one control word a cycle while no step is held,
// and the weight memory has a single read port. The output slot is a
// register, so the next particle can be accepted while the last index of a
// batch is still waiting. The weight memory needs no clearing pass.
// output_count may be written at any time the core is idle.
// ---------------------------------------------------------------------------
module particle_weight_normalize_resample_core #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  pwnr_in_if.sink     particle,
  pwnr_out_if.source  draw,
  pwnr_cfg_if.sink    cfg
);

  // Control word from the microprogram, status back to its jump logic
  pwnr_pkg::ctrl_t   ctrl;
  pwnr_pkg::status_t stat;

  // Step counter, microcode table and jump/hold decision
  pwnr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Weight store, total, walk arithmetic and the output register
  pwnr_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .particle (particle),
    .draw     (draw),
    .cfg      (cfg)
  );

endmodule

// File: src/pwnr_checker.sv
// ---------------------------------------------------------------------------
// pwnr_checker
// Port-level checks on the resampling core, bound to the top level.
// ---------------------------------------------------------------------------
`include "particle_weight_normalize_resample_core_assert.svh"

module pwnr_checker #(
  parameter int MAX_PARTICLES = 64
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pwnr_pkg::OIDX_W-1:0] chosen_index,
  input logic                        uniform_fallback,
  input logic                        run_end
);

  // Index stays inside the store
  `PWNR_ASSERT_NOW(a_idx_range, out_valid, (7'(chosen_index) < 7'(MAX_PARTICLES)))

  // Each particle keeps the core busy after its beat
  `PWNR_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)

  // While loading, only the final index of the previous batch may be pending
  `PWNR_ASSERT_NOW(a_load_after_run, in_ready && out_valid, run_end)

  // Hold a stalled index beat
  `PWNR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(chosen_index) && $stable(uniform_fallback) && $stable(run_end))

endmodule

bind particle_weight_normalize_resample_core pwnr_checker #(
  .MAX_PARTICLES (MAX_PARTICLES)
) u_pwnr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (particle.valid),
  .in_ready         (particle.ready),
  .out_valid        (draw.valid),
  .out_ready        (draw.ready),
  .chosen_index     (draw.chosen_index),
  .uniform_fallback (draw.uniform_fallback),
  .run_end          (draw.run_end)
);
